### sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define GBKD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that must be followed by a condition at the next clock edge.
`define GBKD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### sv/gbkd_pkg.sv
// Package with shared constants and controller-to-datapath types.
package gbkd_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int KEY_BITS_DEF     = 16;

  // Which latched endpoint an edge row access targets.
  localparam logic ROW_A = 1'b0;
  localparam logic ROW_B = 1'b1;

  typedef struct packed {
    logic edge_latch;
    logic key_write;
    logic start;
    logic row_sel;
    logic row_wr;
    logic spread_init;
    logic spread_rd;
    logic spread_done;
    logic sel_init;
    logic sel_rd;
    logic out_load;
    logic idx_inc;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic all_burned;
    logic idx_last;
  } status_t;

endpackage

### sv/graph_burning_key_decoder_top.sv
// Top level of the graph burning key decoder: controller, datapath and checks.
// The block loads an undirected graph one edge transaction at a time and one
// priority key per vertex, then burns the graph in rounds and reports one result
// transaction per round. An edge transaction stalls the input until its row
// updates are done, because each edge does a read-modify-write of two rows in
// the adjacency memory. A key transaction that is not the last one does not
// stall the input. The last key starts the rounds; each round scans all
// MAX_VERTICES adjacency rows to spread the fire and then all MAX_VERTICES keys
// to pick the new source, one row or one key per cycle, and a round is held
// while its result waits behind a stalled output. After the last round the
// controller passes through a check state and a clearing state before the input
// is taken again. A finished result sits in an output register while the next
// round is already being computed. No input transaction is accepted while the
// rounds run. Keys are kept across graphs; the adjacency matrix and the vertex
// masks are cleared after the last result.
module graph_burning_key_decoder_top #(
  parameter int MAX_VERTICES = gbkd_pkg::MAX_VERTICES_DEF,
  parameter int KEY_BITS     = gbkd_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [4:0]  in_endpoint_a,
  input  logic [4:0]  in_endpoint_b,
  input  logic [4:0]  in_key_vertex,
  input  logic [15:0] in_key_value,
  input  logic        in_last_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_round_number,
  output logic [4:0]  out_source_vertex,
  output logic        out_source_valid,
  output logic        out_final_round
);

`include "assert_macros.svh"

  gbkd_pkg::cmd_t    cmd;
  gbkd_pkg::status_t status;

  // The controller owns the handshakes and sequences every step.
  gbkd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_last_key (in_last_key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status)
  );

  // The datapath holds the memories, masks and result registers.
  gbkd_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .KEY_BITS     (KEY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_endpoint_a     (in_endpoint_a),
    .in_endpoint_b     (in_endpoint_b),
    .in_key_vertex     (in_key_vertex),
    .in_key_value      (in_key_value),
    .out_round_number  (out_round_number),
    .out_source_vertex (out_source_vertex),
    .out_source_valid  (out_source_valid),
    .out_final_round   (out_final_round)
  );

  // A round without a new source can only happen when the spread burned the rest.
  `GBKD_ASSERT_ALWAYS(a_nosrc_final, !out_valid || out_source_valid || out_final_round, "round without source is not final")
  // The last key starts the rounds, so the input must stall right after it.
  `GBKD_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_kind && in_last_key, in_stall, "rounds did not start")
  // An edge transaction occupies the block for its row updates.
  `GBKD_ASSERT_NEXT(a_edge_busy, in_valid && !in_stall && !in_kind, in_stall, "edge update skipped")

endmodule

### sv/gbkd_datapath.sv
// Datapath: adjacency and key memories, masks, scan counter and result registers.
module gbkd_datapath #(
  parameter int MAX_VERTICES = gbkd_pkg::MAX_VERTICES_DEF,
  parameter int KEY_BITS     = gbkd_pkg::KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gbkd_pkg::cmd_t   cmd,
  output gbkd_pkg::status_t status,
  input  logic [4:0]       in_endpoint_a,
  input  logic [4:0]       in_endpoint_b,
  input  logic [4:0]       in_key_vertex,
  input  logic [15:0]      in_key_value,
  output logic [5:0]       out_round_number,
  output logic [4:0]       out_source_vertex,
  output logic             out_source_valid,
  output logic             out_final_round
);

  localparam int N  = MAX_VERTICES;
  localparam int VW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]        adj_mem [N];
  logic [KEY_BITS-1:0] key_mem [N];

  logic [N-1:0]        row_valid_r;
  logic [N-1:0]        rowq_r;
  logic                rowv_r;
  logic [KEY_BITS-1:0] keyq_r;
  logic [N-1:0]        present_r;
  logic [N-1:0]        burning_r;
  logic [N-1:0]        acc_r;
  logic [5:0]          round_r;
  logic [VW-1:0]       idx_r;
  logic [VW-1:0]       a_r;
  logic [VW-1:0]       b_r;
  logic                ok_r;
  logic                sp_pend_r;
  logic                sl_pend_r;
  logic [VW-1:0]       pidx_r;
  logic                found_r;
  logic [VW-1:0]       best_r;
  logic [KEY_BITS-1:0] best_key_r;

  logic [VW-1:0] rd_addr;
  logic [VW-1:0] wr_addr;
  logic [VW-1:0] wr_other;
  logic [N-1:0]  row_eff;
  logic [N-1:0]  best_bit;
  logic [N-1:0]  burn_final;
  logic          edge_ok;
  logic          key_ok;
  logic          cand;

  assign edge_ok = (32'(in_endpoint_a) < 32'(N)) && (32'(in_endpoint_b) < 32'(N));
  assign key_ok  = 32'(in_key_vertex) < 32'(N);

  assign wr_addr  = (cmd.row_sel == gbkd_pkg::ROW_B) ? b_r : a_r;
  assign wr_other = (cmd.row_sel == gbkd_pkg::ROW_B) ? a_r : b_r;
  assign rd_addr  = cmd.spread_rd ? idx_r : wr_addr;
  assign row_eff  = rowv_r ? rowq_r : '0;

  assign best_bit   = found_r ? ({{(N-1){1'b0}}, 1'b1} << best_r) : '0;
  assign burn_final = burning_r | best_bit;
  assign cand       = present_r[pidx_r] & ~burning_r[pidx_r];

  assign status.all_burned = (burning_r == present_r);
  assign status.idx_last   = (idx_r == VW'(N - 1));

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.row_wr && ok_r) begin
      adj_mem[wr_addr] <= row_eff | ({{(N-1){1'b0}}, 1'b1} << wr_other);
    end
    rowq_r <= adj_mem[rd_addr];
    if (cmd.key_write && key_ok) begin
      key_mem[VW'(in_key_vertex)] <= KEY_BITS'(in_key_value);
    end
    keyq_r <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rowv_r      <= 1'b0;
      present_r   <= '0;
      burning_r   <= '0;
      round_r     <= '0;
      sp_pend_r   <= 1'b0;
      sl_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      ok_r        <= 1'b0;
    end else begin
      rowv_r    <= row_valid_r[rd_addr];
      sp_pend_r <= cmd.spread_rd;
      sl_pend_r <= cmd.sel_rd;
      pidx_r    <= idx_r;
      if (cmd.edge_latch) begin
        a_r  <= VW'(in_endpoint_a);
        b_r  <= VW'(in_endpoint_b);
        ok_r <= edge_ok;
      end
      if (cmd.row_wr && ok_r) begin
        row_valid_r[wr_addr] <= 1'b1;
        present_r <= present_r | ({{(N-1){1'b0}}, 1'b1} << a_r)
                               | ({{(N-1){1'b0}}, 1'b1} << b_r);
      end
      if (cmd.start) begin
        burning_r <= '0;
        round_r   <= '0;
      end
      if (cmd.spread_init || cmd.sel_init) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + VW'(1);
      end
      if (cmd.spread_init) begin
        acc_r <= burning_r;
      end else if (sp_pend_r && burning_r[pidx_r]) begin
        acc_r <= acc_r | row_eff;
      end
      if (cmd.spread_done) begin
        burning_r <= acc_r & present_r;
      end
      if (cmd.sel_init) begin
        found_r <= 1'b0;
      end else if (sl_pend_r && cand && (!found_r || keyq_r > best_key_r)) begin
        found_r    <= 1'b1;
        best_r     <= pidx_r;
        best_key_r <= keyq_r;
      end
      if (cmd.out_load) begin
        burning_r <= burn_final;
        round_r   <= round_r + 6'd1;
      end
      if (cmd.clear) begin
        row_valid_r <= '0;
        present_r   <= '0;
        burning_r   <= '0;
        round_r     <= '0;
      end
    end
  end

  // Result registers; they hold while the output is stalled.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_round_number  <= round_r + 6'd1;
      out_source_vertex <= found_r ? 5'(best_r) : 5'd0;
      out_source_valid  <= found_r;
      out_final_round   <= (burn_final == present_r);
    end
  end

endmodule

### sv/gbkd_ctrl.sv
// Controller state machine sequencing loads, burning rounds and result hand-off.
module gbkd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic               in_last_key,
  output logic               out_valid,
  input  logic               out_stall,
  output gbkd_pkg::cmd_t     cmd,
  input  gbkd_pkg::status_t  status
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EA_RD    = 4'd1;
  localparam logic [3:0] S_EA_WR    = 4'd2;
  localparam logic [3:0] S_EB_RD    = 4'd3;
  localparam logic [3:0] S_EB_WR    = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_SPREAD   = 4'd6;
  localparam logic [3:0] S_SP_END   = 4'd7;
  localparam logic [3:0] S_SEL_INIT = 4'd8;
  localparam logic [3:0] S_SEL      = 4'd9;
  localparam logic [3:0] S_SEL_END  = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;
  localparam logic [3:0] S_CLEAR    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            cmd.edge_latch = 1'b1;
            state_nxt      = S_EA_RD;
          end else begin
            cmd.key_write = 1'b1;
            if (in_last_key) begin
              cmd.start = 1'b1;
              state_nxt = S_CHECK;
            end
          end
        end
      end
      S_EA_RD: begin
        cmd.row_sel = gbkd_pkg::ROW_A;
        state_nxt   = S_EA_WR;
      end
      S_EA_WR: begin
        cmd.row_sel = gbkd_pkg::ROW_A;
        cmd.row_wr  = 1'b1;
        state_nxt   = S_EB_RD;
      end
      S_EB_RD: begin
        cmd.row_sel = gbkd_pkg::ROW_B;
        state_nxt   = S_EB_WR;
      end
      S_EB_WR: begin
        cmd.row_sel = gbkd_pkg::ROW_B;
        cmd.row_wr  = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CHECK: begin
        if (status.all_burned) begin
          state_nxt = S_CLEAR;
        end else begin
          cmd.spread_init = 1'b1;
          state_nxt       = S_SPREAD;
        end
      end
      S_SPREAD: begin
        cmd.spread_rd = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (status.idx_last) begin
          state_nxt = S_SP_END;
        end
      end
      S_SP_END: begin
        state_nxt = S_SEL_INIT;
      end
      S_SEL_INIT: begin
        cmd.spread_done = 1'b1;
        cmd.sel_init    = 1'b1;
        state_nxt       = S_SEL;
      end
      S_SEL: begin
        cmd.sel_rd  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (status.idx_last) begin
          state_nxt = S_SEL_END;
        end
      end
      S_SEL_END: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### verif/tb.sv
// Testbench for the graph burning key decoder: random graphs, burn-order checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = gbkd_pkg::MAX_VERTICES_DEF;
  localparam bit KIND_EDGE = 1'b0;
  localparam bit KIND_KEY  = 1'b1;

  typedef struct packed {
    logic [5:0] round_number;
    logic [4:0] source_vertex;
    logic       source_valid;
    logic       final_round;
  } round_t;

  // The scoreboard holds its own copy of the graph, the keys and the vertex masks.
  // It burns the graph when the last key arrives and queues one round per result.
  class burn_scoreboard;
    logic [31:0] adj_rows [NV];
    logic [15:0] keys [NV];
    logic [31:0] present;
    round_t      pending_rounds [$];
    int          errors;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      foreach (keys[i]) keys[i] = '0;
      present = '0;
      errors = 0;
    endfunction

    function void burn_graph();
      logic [31:0] burning;
      logic [31:0] spread;
      logic [31:0] cand;
      logic [5:0]  rnd;
      int          best;
      round_t      r;
      burning = '0;
      rnd = '0;
      while (burning != present) begin
        spread = burning;
        for (int v = 0; v < NV; v++)
          if (burning[v]) spread |= adj_rows[v];
        burning = spread & present;
        cand = present & ~burning;
        best = -1;
        for (int v = 0; v < NV; v++)
          if (cand[v] && (best < 0 || keys[v] > keys[best])) best = v;
        if (best >= 0) burning[best] = 1'b1;
        rnd++;
        r.round_number  = rnd;
        r.source_vertex = (best >= 0) ? best[4:0] : 5'd0;
        r.source_valid  = (best >= 0);
        r.final_round   = (burning == present);
        pending_rounds.insert(pending_rounds.size(), r);
      end
      foreach (adj_rows[i]) adj_rows[i] = '0;
      present = '0;
    endfunction

    function void note_input(bit kind, logic [4:0] a, logic [4:0] b, logic [4:0] kv,
                             logic [15:0] val, bit last);
      if (kind == KIND_EDGE) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
        present[a] = 1'b1;
        present[b] = 1'b1;
      end else begin
        keys[kv] = val;
        if (last) burn_graph();
      end
    endfunction

    function void check_round(round_t got);
      round_t exp_r;
      if (pending_rounds.size() == 0) begin
        $error("unexpected result transaction: round %0d", got.round_number);
        errors++;
        return;
      end
      exp_r = pending_rounds.pop_front();
      if (got.round_number !== exp_r.round_number) begin
        $error("round_number: expected %0d, actual %0d", exp_r.round_number,
               got.round_number);
        errors++;
      end
      if (got.source_vertex !== exp_r.source_vertex) begin
        $error("source_vertex: expected %0d, actual %0d", exp_r.source_vertex,
               got.source_vertex);
        errors++;
      end
      if (got.source_valid !== exp_r.source_valid) begin
        $error("source_valid: expected %0d, actual %0d", exp_r.source_valid,
               got.source_valid);
        errors++;
      end
      if (got.final_round !== exp_r.final_round) begin
        $error("final_round: expected %0d, actual %0d", exp_r.final_round,
               got.final_round);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [4:0]  in_endpoint_a;
  logic [4:0]  in_endpoint_b;
  logic [4:0]  in_key_vertex;
  logic [15:0] in_key_value;
  logic        in_last_key;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_round_number;
  logic [4:0]  out_source_vertex;
  logic        out_source_valid;
  logic        out_final_round;

  burn_scoreboard sb;
  bit             stim_done;
  bit             long_hold;
  int             cycle_count;
  logic [31:0]    keyed;

  graph_burning_key_decoder_top dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every accepted input transaction is handed to the scoreboard at the same edge
  // at which the block takes it, so expectations always precede results.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_input(in_kind, in_endpoint_a, in_endpoint_b, in_key_vertex,
                    in_key_value, in_last_key);
    if (rst_n && out_valid && !out_stall)
      sb.check_round({out_round_number, out_source_vertex, out_source_valid,
                      out_final_round});
  end

  // The receiver stalls on its own pattern: quiet stretches, random stalls and
  // one long hold-off that lets the block fill up and push back on its input.
  initial begin
    int mode;
    out_stall <= 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // The sender works in bursts; between bursts it drops valid for a random pause.
  int burst_left;
  int sent_count;

  task automatic send_item(bit kind, logic [4:0] a, logic [4:0] b, logic [4:0] kv,
                           logic [15:0] val, bit last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_endpoint_a <= a;
    in_endpoint_b <= b;
    in_key_vertex <= kv;
    in_key_value  <= val;
    in_last_key   <= last;
    @(posedge clk iff !in_stall);
    sent_count++;
  endtask

  task automatic send_edge(logic [4:0] a, logic [4:0] b);
    keyed[a] = 1'b1;
    keyed[b] = 1'b1;
    send_item(KIND_EDGE, a, b, 5'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_key(logic [4:0] kv, logic [15:0] val, bit last);
    send_item(KIND_KEY, 5'($urandom), 5'($urandom), kv, val, last);
  endtask

  // Keys every vertex of the current graph, then sends the last key, which may
  // name any vertex since every key has been written at least once by then.
  task automatic close_graph(bit rand_keys);
    for (int v = 0; v < NV; v++)
      if (keyed[v]) send_key(v[4:0], rand_keys ? 16'($urandom) : 16'hffff, 1'b0);
    send_key(5'($urandom), 16'($urandom), 1'b1);
    keyed = '0;
  endtask

  task automatic random_graph();
    int n_edges;
    int span;
    logic [4:0] a;
    span = ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(1, 12);
    n_edges = $urandom_range(1, 14);
    for (int i = 0; i < n_edges; i++) begin
      a = 5'($urandom_range(0, span));
      // Mostly chains and near neighbors so fire actually spreads over rounds.
      if ($urandom_range(0, 2) != 0)
        send_edge(a, 5'($urandom_range(0, span)));
      else
        send_edge(a, (a == 5'd31) ? 5'd0 : a + 5'd1);
    end
    close_graph(1'b1);
  endtask

  initial begin
    sb = new();
    keyed = '0;
    burst_left = 0;
    sent_count = 0;
    stim_done = 1'b0;
    long_hold = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_EDGE;
    in_endpoint_a <= '0;
    in_endpoint_b <= '0;
    in_key_vertex <= '0;
    in_key_value <= '0;
    in_last_key <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any key exists, initialize all of them so that later graphs never
    // read an unwritten key. The extreme key values appear here.
    for (int v = 0; v < NV; v++)
      send_key(v[4:0], (v % 2) ? 16'hffff : 16'h0000, 1'b0);
    // Empty graph: the last key alone produces no result.
    send_key(5'd31, 16'h0000, 1'b1);
    // Extreme endpoints, a self loop, and equal keys where the lowest index wins.
    send_edge(5'd0, 5'd31);
    send_edge(5'd5, 5'd5);
    send_key(5'd0, 16'h8000, 1'b0);
    send_key(5'd31, 16'h8000, 1'b0);
    send_key(5'd5, 16'h8000, 1'b1);
    // A star: spread from the hub alone finishes, giving a sourceless round.
    for (int v = 1; v < 6; v++) send_edge(5'd10, v[4:0]);
    send_key(5'd10, 16'hffff, 1'b0);
    send_key(5'd1, 16'h0001, 1'b1);

    // Long receiver hold-off while graphs keep coming. The closing path graph
    // below adds about 64 more transactions.
    long_hold = 1'b1;
    while (sent_count < 336) random_graph();
    // A long path over all vertices gives a long run of rounds.
    for (int v = 0; v < NV - 1; v++) send_edge(v[4:0], v[4:0] + 5'd1);
    close_graph(1'b0);
    in_valid <= 1'b0;
    // Wait so that the last transaction is surely in the scoreboard.
    @(posedge clk);
    stim_done = 1'b1;
  end

  // Run end: wait until every expected round has arrived, then drain a little.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("tb: FAIL");
        $finish;
      end
      if (stim_done && sb.pending_rounds.size() == 0) begin
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rounds.size() == 0)
          $display("tb: PASS");
        else
          $display("tb: FAIL");
        $finish;
      end
    end
  end
endmodule

### graph_burning_key_decoder_top.f
+incdir+sv
sv/gbkd_pkg.sv
sv/gbkd_datapath.sv
sv/gbkd_ctrl.sv
sv/graph_burning_key_decoder_top.sv
verif/tb.sv
